// ===== hw/rtl/lrut_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrut_pkg;

   // default table depth
   localparam int unsigned ENTRIES_DEFAULT = 16;

   // command codes
   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_FORGET = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // status codes
   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_APPENDED  = 3'd1;
   localparam logic [2:0] ST_REPLACED  = 3'd2;
   localparam logic [2:0] ST_FORGOT    = 3'd3;
   localparam logic [2:0] ST_READ_OK   = 3'd4;
   localparam logic [2:0] ST_READ_OOR  = 3'd5;
   localparam logic [2:0] ST_CLEARED   = 3'd6;

   // request transfer
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] chara_ref;
      logic [31:0] param_ref;
      logic [31:0] now;
      logic [3:0]  read_index;
   } req_type;

   // response transfer
   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [4:0]  removed_count;
      logic [4:0]  entry_count;
      logic [31:0] out_key;
      logic [31:0] out_chara_ref;
      logic [31:0] out_param_ref;
      logic [31:0] out_hits;
      logic [31:0] out_last_seen;
   } rsp_type;

   // one table entry as stored in the entry ram
   typedef struct packed {
      logic [31:0] key;
      logic [31:0] chara;
      logic [31:0] param;
      logic [31:0] hits;
      logic [31:0] seen;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ===== hw/rtl/lrut_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrut_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_tracking_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Associative table of up to ENTRIES keys with least-last-seen replacement. All
// entry fields live in one single-port-read entry ram, so a command that reads
// entries does so as a sequence of ram reads at one entry per cycle. A request
// is taken only while the sequencer is idle; its response lands in an output
// register, so the next request can be taken while that response is still
// waiting. Clear needs no ram read, and read fetches its one entry unless the
// index is out of range. Record checks the most recently used slot first when
// it is in use, then searches the table on a miss (which also finds the oldest
// entry for replacement). Forget walks the table once, filling each hole from
// the last entry and checking it in place. No clearing pass is needed after
// reset or clear: entries at or beyond the entry count are never read.
module lru_tracking_table_top
   import lrut_pkg::*;
#(
   parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RECENT = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_FCHK   = 3'd4;
   localparam logic [2:0] S_FMOVE  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] recent_ff, recent_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic [31:0]      min_seen_ff, min_seen_in;
   logic [IDX_W-1:0] min_slot_ff, min_slot_in;
   rsp_type          resp_ff, resp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // entry ram ports
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   entry_type        ent;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] count_m2;
   logic [CNT_W-1:0] idx_cnt;
   logic [CNT_W-1:0] idx_next_cnt;
   logic             key_match;
   logic             forget_match;
   logic             min_take;
   logic [IDX_W-1:0] repl_slot;

   lrut_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // helpers on the entry read last cycle
   assign ent          = entry_type'(ram_rd_data);
   assign count_m1     = count_ff - CNT_W'(1);
   assign count_m2     = count_ff - CNT_W'(2);
   assign idx_cnt      = CNT_W'(idx_ff);
   assign idx_next_cnt = idx_cnt + CNT_W'(1);
   assign key_match    = (ent.key == req_ff.key);
   assign forget_match = (ent.key == req_ff.key) || (ent.chara == req_ff.key);
   assign min_take     = (idx_ff == '0) || (ent.seen < min_seen_ff);
   assign repl_slot    = min_take ? idx_ff : min_slot_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      count_in    = count_ff;
      recent_in   = recent_ff;
      idx_in      = idx_ff;
      removed_in  = removed_ff;
      min_seen_in = min_seen_ff;
      min_slot_in = min_slot_ff;
      resp_in     = resp_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ent;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               removed_in = '0;
               resp_in    = '0;
               case (req_data.cmd)
                  CMD_RECORD: begin
                     if (CNT_W'(recent_ff) < count_ff) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = recent_ff;
                        state_in    = S_RECENT;
                     end else if (count_ff == '0) begin
                        // empty table: append at slot zero right away
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = '0;
                        ram_wr_data.key   = req_data.key;
                        ram_wr_data.chara = req_data.chara_ref;
                        ram_wr_data.param = req_data.param_ref;
                        ram_wr_data.hits  = 32'd1;
                        ram_wr_data.seen  = req_data.now;
                        count_in          = CNT_W'(1);
                        recent_in         = '0;
                        resp_in.status      = ST_APPENDED;
                        resp_in.entry_count = 5'd1;
                        state_in          = S_DONE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  CMD_FORGET: begin
                     if (count_ff == '0) begin
                        resp_in.status = ST_FORGOT;
                        state_in       = S_DONE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_FCHK;
                     end
                  end
                  CMD_READ: begin
                     if (32'(req_data.read_index) < 32'(count_ff)) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(req_data.read_index);
                        state_in    = S_READ;
                     end else begin
                        resp_in.status      = ST_READ_OOR;
                        resp_in.slot        = req_data.read_index;
                        resp_in.entry_count = 5'(count_ff);
                        state_in            = S_DONE;
                     end
                  end
                  default: begin
                     count_in       = '0;
                     recent_in      = '0;
                     resp_in.status = ST_CLEARED;
                     state_in       = S_DONE;
                  end
               endcase
            end
         end

         // most recently used slot checked first
         S_RECENT: begin
            if (key_match) begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = recent_ff;
               ram_wr_data.chara = req_ff.chara_ref;
               ram_wr_data.hits  = ent.hits + 32'd1;
               ram_wr_data.seen  = req_ff.now;
               resp_in.status      = ST_HIT;
               resp_in.slot        = 4'(recent_ff);
               resp_in.entry_count = 5'(count_ff);
               state_in          = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               idx_in      = '0;
               state_in    = S_SCAN;
            end
         end

         // search in index order, tracking the oldest entry along the way
         S_SCAN: begin
            if (min_take) begin
               min_seen_in = ent.seen;
               min_slot_in = idx_ff;
            end
            if (key_match) begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = idx_ff;
               ram_wr_data.chara = req_ff.chara_ref;
               ram_wr_data.hits  = ent.hits + 32'd1;
               ram_wr_data.seen  = req_ff.now;
               recent_in         = idx_ff;
               resp_in.status      = ST_HIT;
               resp_in.slot        = 4'(idx_ff);
               resp_in.entry_count = 5'(count_ff);
               state_in          = S_DONE;
            end else if (idx_cnt == count_m1) begin
               // miss: append, or replace the oldest when full
               ram_wr_en         = 1'b1;
               ram_wr_data.key   = req_ff.key;
               ram_wr_data.chara = req_ff.chara_ref;
               ram_wr_data.param = req_ff.param_ref;
               ram_wr_data.hits  = 32'd1;
               ram_wr_data.seen  = req_ff.now;
               if (count_ff == FULL_COUNT) begin
                  ram_wr_addr         = repl_slot;
                  recent_in           = repl_slot;
                  resp_in.status      = ST_REPLACED;
                  resp_in.slot        = 4'(repl_slot);
                  resp_in.entry_count = 5'(count_ff);
               end else begin
                  ram_wr_addr         = IDX_W'(count_ff);
                  recent_in           = IDX_W'(count_ff);
                  count_in            = count_ff + CNT_W'(1);
                  resp_in.status      = ST_APPENDED;
                  resp_in.slot        = 4'(count_ff);
                  resp_in.entry_count = 5'(count_ff + CNT_W'(1));
               end
               state_in = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + IDX_W'(1);
               idx_in      = idx_ff + IDX_W'(1);
            end
         end

         S_READ: begin
            resp_in.status        = ST_READ_OK;
            resp_in.slot          = req_ff.read_index;
            resp_in.entry_count   = 5'(count_ff);
            resp_in.out_key       = ent.key;
            resp_in.out_chara_ref = ent.chara;
            resp_in.out_param_ref = ent.param;
            resp_in.out_hits      = ent.hits;
            resp_in.out_last_seen = ent.seen;
            state_in              = S_DONE;
         end

         // forget: check entry at idx
         S_FCHK: begin
            resp_in.status = ST_FORGOT;
            if (forget_match) begin
               if (idx_cnt == count_m1) begin
                  count_in              = count_m1;
                  resp_in.removed_count = 5'(removed_ff + CNT_W'(1));
                  resp_in.entry_count   = 5'(count_m1);
                  state_in              = S_DONE;
               end else begin
                  // fetch the last entry to fill the hole
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(count_m1);
                  state_in    = S_FMOVE;
               end
            end else if (idx_next_cnt < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + IDX_W'(1);
               idx_in      = idx_ff + IDX_W'(1);
            end else begin
               resp_in.removed_count = 5'(removed_ff);
               resp_in.entry_count   = 5'(count_ff);
               state_in              = S_DONE;
            end
         end

         // forget: last entry arrives, move it into the hole and check it
         S_FMOVE: begin
            resp_in.status = ST_FORGOT;
            ram_wr_en      = 1'b1;
            ram_wr_addr    = idx_ff;
            count_in       = count_m1;
            removed_in     = removed_ff + CNT_W'(1);
            if (forget_match) begin
               if (idx_cnt == count_m2) begin
                  count_in              = count_m2;
                  resp_in.removed_count = 5'(removed_ff + CNT_W'(2));
                  resp_in.entry_count   = 5'(count_m2);
                  state_in              = S_DONE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(count_m2);
               end
            end else if (idx_next_cnt < count_m1) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + IDX_W'(1);
               idx_in      = idx_ff + IDX_W'(1);
               state_in    = S_FCHK;
            end else begin
               resp_in.removed_count = 5'(removed_ff + CNT_W'(1));
               resp_in.entry_count   = 5'(count_m1);
               state_in              = S_DONE;
            end
         end

         // hand the response to the output register when it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = resp_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         recent_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         recent_ff    <= recent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      removed_ff  <= removed_in;
      min_seen_ff <= min_seen_in;
      min_slot_ff <= min_slot_in;
      resp_ff     <= resp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
